// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the selector RTL.
// Assertions are compiled only when SYNTHESIS is not set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define ALPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true outside reset
`define ALPS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ALPS_ASSERT(lbl, clk, rstn, prop, msg)
`define ALPS_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// ===== rtl/core/alps_pkg.sv =====
// Package for the aged longest packet selector: field widths, codes,
// entry layout and the controller/datapath interface structs. No dependencies.
package alps_pkg;

  localparam int ALPS_WINDOW_DEF = 256;
  localparam int ALPS_DEPTH_DEF  = 1024;

  localparam int LEN_W  = 16;
  localparam int TIME_W = 48;
  localparam int ID_W   = 32;
  localparam int SEL_W  = 8;
  localparam int STAT_W = 2;
  localparam int CMD_W  = 1;

  localparam int IN_DATA_W  = 176;  // 16 + 48 + 32 + 32 + 48
  localparam int OUT_DATA_W = 136;  // 8 + 16 + 48 + 32 + 32

  localparam logic [TIME_W-1:0] THR_RESET = 48'd1000;

  // command codes carried in in_tuser
  localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

  // result status codes carried in out_tuser
  localparam logic [STAT_W-1:0] ST_PUSHED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_POPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

  // one queue entry, length in the lowest bits
  typedef struct packed {
    logic [ID_W-1:0]   flow_id;
    logic [ID_W-1:0]   pkt_id;
    logic [TIME_W-1:0] arrival;
    logic [LEN_W-1:0]  length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_CAPT,
    S_MOVE,
    S_DONE
  } alps_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic fetch;
    logic capture;
    logic move;
    logic dec_occ;
    logic load_out;
  } alps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_go;
    logic scan_done;
    logic move_done;
    logic out_free;
  } alps_stat_t;

endpackage

// ===== rtl/core/alps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module alps_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/alps_ctrl.sv =====
// Sequencing state machine of the selector: push, scan, fetch, compaction, result.
// Depends on alps_pkg and assert_macros.svh.
`include "assert_macros.svh"
module alps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  alps_pkg::alps_stat_t st,
  output alps_pkg::alps_cmd_t  cmd
);
  import alps_pkg::*;

  alps_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = st.pop_go ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (st.scan_done) state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_CAPT;
      S_CAPT:  state_nxt = S_MOVE;
      S_MOVE: begin
        if (st.move_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_SCAN:  cmd.scan    = 1'b1;
      S_FETCH: cmd.fetch   = 1'b1;
      S_CAPT:  cmd.capture = 1'b1;
      S_MOVE: begin
        cmd.move    = 1'b1;
        cmd.dec_occ = st.move_done;
      end
      S_DONE:  cmd.load_out = st.out_free;
      default: cmd = '0;
    endcase
  end

  `ALPS_ASSERT(a_capt_to_move, clk, rst_n, (state_r == S_CAPT) |=> (state_r == S_MOVE), "capture not followed by move")
  `ALPS_ASSERT(a_fetch_after_scan, clk, rst_n, (state_r == S_FETCH) |-> ($past(state_r) == S_SCAN), "fetch without scan")

endmodule

// ===== rtl/core/alps_dp.sv =====
// Datapath of the selector: queue memory, occupancy, windowed aged scan,
// compaction and the result register. Depends on alps_pkg, alps_ram, assert_macros.svh.
`include "assert_macros.svh"
module alps_dp #(
  parameter int WINDOW      = alps_pkg::ALPS_WINDOW_DEF,
  parameter int QUEUE_DEPTH = alps_pkg::ALPS_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  alps_pkg::alps_cmd_t               cmd,
  output alps_pkg::alps_stat_t              st,
  input  logic [alps_pkg::CMD_W-1:0]        in_tuser,
  input  logic [alps_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              cfg_tvalid,
  output logic                              cfg_tready,
  input  logic [alps_pkg::TIME_W-1:0]       cfg_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [alps_pkg::STAT_W-1:0]       out_tuser,
  output logic [alps_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import alps_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);       // address width
  localparam int OW = $clog2(QUEUE_DEPTH + 1);   // occupancy width
  localparam logic [OW-1:0] DEPTH_OCC = OW'(QUEUE_DEPTH);

  // input fields
  logic [LEN_W-1:0]  in_len;
  logic [TIME_W-1:0] in_arr;
  logic [ID_W-1:0]   in_pid;
  logic [ID_W-1:0]   in_fid;
  logic [TIME_W-1:0] in_now;
  assign in_len = in_tdata[15:0];
  assign in_arr = in_tdata[63:16];
  assign in_pid = in_tdata[95:64];
  assign in_fid = in_tdata[127:96];
  assign in_now = in_tdata[175:128];

  logic [OW-1:0]     occ_r;
  logic [TIME_W-1:0] thr_r;
  logic [TIME_W-1:0] now_r;
  logic [OW-1:0]     rp_r;        // read pointer for scan and compaction
  logic              v1_r;        // read data valid for scan
  logic [QW-1:0]     idx1_r;
  logic              v2_r;        // eligible candidate stage
  logic [LEN_W-1:0]  len2_r;
  logic [QW-1:0]     idx2_r;
  logic [LEN_W-1:0]  best_r;
  logic [QW-1:0]     pick_r;
  logic              mv_v_r;
  logic [QW-1:0]     mv_addr_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] res_stat_r;
  logic [SEL_W-1:0]  res_sel_r;
  entry_t            res_ent_r;
  logic [STAT_W-1:0] o_stat_r;
  logic [SEL_W-1:0]  o_sel_r;
  entry_t            o_ent_r;

  // memory ports
  logic          ram_we, ram_re;
  logic [QW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic          full, empty, push_we;
  logic [OW-1:0] limit;
  logic          scan_issue, move_issue;
  logic [OW-1:0] rp_m1;
  logic [TIME_W:0] wait_diff;
  logic            elig;

  assign full    = (occ_r == DEPTH_OCC);
  assign empty   = (occ_r == '0);
  assign push_we = cmd.accept && (in_tuser == CMD_PUSH) && !full;

  // scan limit is the smaller of occupancy and window
  assign limit = (32'(occ_r) < WINDOW) ? occ_r : OW'(WINDOW);

  assign scan_issue = cmd.scan && (rp_r < limit);
  assign move_issue = cmd.move && (rp_r < occ_r);
  assign rp_m1      = rp_r - OW'(1);

  // eligibility: now >= arrival and wait strictly above threshold
  assign wait_diff = {1'b0, now_r} - {1'b0, ram_rdata.arrival};
  assign elig      = !wait_diff[TIME_W] && (wait_diff[TIME_W-1:0] > thr_r);

  // memory access mux
  always_comb begin
    ram_we    = push_we || mv_v_r;
    ram_waddr = push_we ? occ_r[QW-1:0] : mv_addr_r;
    ram_wdata = push_we ? entry_t'{flow_id: in_fid, pkt_id: in_pid,
                                   arrival: in_arr, length: in_len}
                        : ram_rdata;
    ram_re    = scan_issue || cmd.fetch || move_issue;
    ram_raddr = cmd.fetch ? pick_r : rp_r[QW-1:0];
  end

  alps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      thr_r       <= THR_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      mv_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_tvalid) thr_r <= cfg_tdata;
      if (push_we) begin
        occ_r <= occ_r + OW'(1);
      end else if (cmd.dec_occ) begin
        occ_r <= occ_r - OW'(1);
      end
      v1_r   <= scan_issue;
      v2_r   <= v1_r && elig;
      mv_v_r <= move_issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan, pick and compaction payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r     <= in_now;
      rp_r      <= '0;
      best_r    <= '0;
      pick_r    <= '0;
      res_sel_r <= '0;
      res_ent_r <= '0;
      if (in_tuser == CMD_PUSH) begin
        res_stat_r <= full ? ST_FULL : ST_PUSHED;
      end else begin
        res_stat_r <= empty ? ST_EMPTY : ST_POPPED;
      end
    end
    if (scan_issue || move_issue) rp_r <= rp_r + OW'(1);
    if (cmd.fetch) rp_r <= OW'(pick_r) + OW'(1);
    idx1_r    <= rp_r[QW-1:0];
    len2_r    <= ram_rdata.length;
    idx2_r    <= idx1_r;
    mv_addr_r <= rp_m1[QW-1:0];
    // keep the first strictly longer candidate
    if (v2_r && (len2_r > best_r)) begin
      best_r <= len2_r;
      pick_r <= idx2_r;
    end
    if (cmd.capture) begin
      res_ent_r <= ram_rdata;
      res_sel_r <= SEL_W'(pick_r);
    end
    if (cmd.load_out) begin
      o_stat_r <= res_stat_r;
      o_sel_r  <= res_sel_r;
      o_ent_r  <= res_ent_r;
    end
  end

  // status to controller
  assign st.pop_go    = (in_tuser == CMD_POP) && !empty;
  assign st.scan_done = (rp_r >= limit) && !v1_r && !v2_r;
  assign st.move_done = (rp_r >= occ_r) && !mv_v_r;
  assign st.out_free  = !out_valid_r || out_tready;

  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_stat_r;
  assign out_tdata  = {o_ent_r.flow_id, o_ent_r.pkt_id, o_ent_r.arrival,
                       o_ent_r.length, o_sel_r};

  `ALPS_ASSERT(a_occ_max, clk, rst_n, occ_r <= DEPTH_OCC, "occupancy above depth")
  `ALPS_ASSERT_NEVER(a_wr_clash, clk, rst_n, push_we && mv_v_r, "push write during compaction")
  `ALPS_ASSERT(a_pick_range, clk, rst_n, cmd.fetch |-> (OW'(pick_r) < occ_r), "pick beyond occupancy")
  `ALPS_ASSERT(a_dec_nonzero, clk, rst_n, cmd.dec_occ |-> !empty, "pop from empty queue")

endmodule

// ===== rtl/core/aged_longest_packet_selector_unit.sv =====
// Aged longest packet selector: an ordered packet queue with a windowed,
// aged, longest-first pop.
// Beats on in_t* carry a push or pop command; every accepted beat yields one
// result beat on out_t*. age_threshold is written through cfg_t* (always ready);
// it must be written only while the unit is idle; the block itself has no check
// for this. Reset empties the queue and sets the threshold to 1000. A push, a
// refused push and a pop on an empty queue go from acceptance straight to
// loading the result into the output register. A pop scans min(occupancy,
// WINDOW) entries (one memory read per entry), fetches the pick, then compacts
// the occupancy - pick - 1 entries behind it (one entry moved per cycle through
// the single queue RAM, none when the pick is the tail), and loads the result.
// One item is worked on at a time; the next beat is accepted as soon as the
// result sits in the output register, even if the receiver stalls out_tready.
// A full output register holds its beat and the unit then waits to load the
// next result until it is taken.
// Depends on alps_pkg, alps_ctrl, alps_dp, alps_ram.
module aged_longest_packet_selector_unit #(
  parameter int WINDOW      = alps_pkg::ALPS_WINDOW_DEF,
  parameter int QUEUE_DEPTH = alps_pkg::ALPS_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [alps_pkg::CMD_W-1:0]      in_tuser,   // cmd
  // pkt_length, arrival_time, pkt_id, flow_id, now_time
  input  logic [alps_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            cfg_tvalid,
  output logic                            cfg_tready,
  input  logic [alps_pkg::TIME_W-1:0]     cfg_tdata,  // age_threshold
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [alps_pkg::STAT_W-1:0]     out_tuser,  // status
  // sel_index, out_length, out_arrival, out_pkt_id, out_flow_id
  output logic [alps_pkg::OUT_DATA_W-1:0] out_tdata
);
  import alps_pkg::*;

  alps_cmd_t  cmd;
  alps_stat_t st;

  alps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  alps_dp #(
    .WINDOW      (WINDOW),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/tb_aged_longest_packet_selector_unit.sv =====
// Self-checking testbench for aged_longest_packet_selector_unit: directed table, then
// random push/pop traffic against a queue predictor, with stalls on both streams.
// Ends by filling past the window. Depends on alps_pkg and the selector RTL.
module tb_aged_longest_packet_selector_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import alps_pkg::*;

  localparam int WIN   = ALPS_WINDOW_DEF;
  localparam int DEPTH = ALPS_DEPTH_DEF;
  localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one command beat as the sender sees it
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] arrival;
    logic [ID_W-1:0]   pkt_id;
    logic [ID_W-1:0]   flow_id;
    logic [TIME_W-1:0] now;
  } pkt_cmd_t;

  // one result beat, unpacked
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEL_W-1:0]  sel;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] arrival;
    logic [ID_W-1:0]   pkt_id;
    logic [ID_W-1:0]   flow_id;
  } sel_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    pkt_cmd_t          c;
    logic [TIME_W-1:0] thr;
    logic              typed;
    sel_result_t       want;
  } plan_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [TIME_W-1:0]     cfg_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [STAT_W-1:0]     out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state: packet queue in order and the threshold register
  entry_t            pkt_q[$];
  logic [TIME_W-1:0] age_thr = THR_RESET;
  sel_result_t       sel_exp_q[$];

  // directed stimulus table
  plan_row_t         plan[$];

  logic            tx_idle_en = 1'b0;
  logic            rx_idle_en = 1'b0;
  int              n_fail     = 0;
  int              n_checked  = 0;
  int              n_sent     = 0;
  int              n_thr_wr   = 0;
  int              max_occ    = 0;
  int              n_by_status[4] = '{0, 0, 0, 0};
  longint unsigned n_cycles   = 0;

  aged_longest_packet_selector_unit #(
    .WINDOW      (WIN),
    .QUEUE_DEPTH (DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic logic [TIME_W-1:0] rand48();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic sel_result_t status_only(logic [STAT_W-1:0] st);
    sel_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // push command; now_time is a don't-care and gets noise
  function automatic pkt_cmd_t mk_push(logic [LEN_W-1:0] len, logic [TIME_W-1:0] arr,
                                       logic [ID_W-1:0] pid, logic [ID_W-1:0] fid);
    pkt_cmd_t c;
    c.cmd = CMD_PUSH;
    c.len = len;
    c.arrival = arr;
    c.pkt_id = pid;
    c.flow_id = fid;
    c.now = rand48();
    return c;
  endfunction

  // pop command; packet fields are don't-cares and get noise
  function automatic pkt_cmd_t mk_pop(logic [TIME_W-1:0] now);
    pkt_cmd_t c;
    c.cmd = CMD_POP;
    c.len = LEN_W'($urandom);
    c.arrival = rand48();
    c.pkt_id = $urandom;
    c.flow_id = $urandom;
    c.now = now;
    return c;
  endfunction

  function automatic plan_row_t item_row(pkt_cmd_t c);
    return '{ROW_ITEM, c, '0, 1'b0, '0};
  endfunction

  function automatic plan_row_t typed_row(pkt_cmd_t c, sel_result_t want);
    return '{ROW_ITEM, c, '0, 1'b1, want};
  endfunction

  function automatic plan_row_t cfg_row(logic [TIME_W-1:0] v);
    return '{ROW_CFG, '0, v, 1'b0, '0};
  endfunction

  // append one row to the directed table
  function automatic void add_row(plan_row_t row);
    plan.insert(plan.size(), row);
  endfunction

  // queue predictor: push at tail, aged longest-first pop within the window
  function automatic sel_result_t predict_select(pkt_cmd_t c);
    sel_result_t r;
    entry_t e;
    int limit;
    int pick;
    logic [LEN_W-1:0] best;
    if (c.cmd == CMD_PUSH) begin
      if (pkt_q.size() >= DEPTH) return status_only(ST_FULL);
      e.length = c.len;
      e.arrival = c.arrival;
      e.pkt_id = c.pkt_id;
      e.flow_id = c.flow_id;
      pkt_q.insert(pkt_q.size(), e);
      return status_only(ST_PUSHED);
    end
    if (pkt_q.size() == 0) return status_only(ST_EMPTY);
    limit = (pkt_q.size() < WIN) ? pkt_q.size() : WIN;
    pick = 0;
    best = '0;
    for (int i = 0; i < limit; i++) begin
      if (c.now >= pkt_q[i].arrival && (c.now - pkt_q[i].arrival) > age_thr &&
          pkt_q[i].length > best) begin
        best = pkt_q[i].length;
        pick = i;
      end
    end
    e = pkt_q[pick];
    pkt_q.delete(pick);
    r.status = ST_POPPED;
    r.sel = SEL_W'(pick);
    r.len = e.length;
    r.arrival = e.arrival;
    r.pkt_id = e.pkt_id;
    r.flow_id = e.flow_id;
    return r;
  endfunction

  // drive one command beat, wait for acceptance, then log what must come back
  task automatic send_item(pkt_cmd_t c, logic typed, sel_result_t want);
    int gap;
    int r;
    sel_result_t p;
    gap = 0;
    if (tx_idle_en) begin
      r = $urandom_range(0, 99);
      if (r >= 55)
        gap = (r < 90) ? $urandom_range(1, 3) : (r < 97) ? $urandom_range(4, 12) :
              $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= {c.now, c.flow_id, c.pkt_id, c.arrival, c.len};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    p = predict_select(c);
    n_sent++;
    n_by_status[p.status]++;
    if (pkt_q.size() > max_occ) max_occ = pkt_q.size();
    sel_exp_q.insert(sel_exp_q.size(), typed ? want : p);
  endtask

  // stop sending and wait until every result beat is back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sel_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(logic [TIME_W-1:0] v);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= v;
    do @(negedge clk); while (!cfg_tready);
    @(posedge clk);
    cfg_tvalid <= 1'b0;
    age_thr = v;
    n_thr_wr++;
  endtask

  task automatic report_field(string name, logic [63:0] e, logic [63:0] a);
    n_fail++;
    $error("%s: expected %0h, got %0h", name, e, a);
  endtask

  // receiver: random stalls on out_tready
  always @(posedge clk) begin : rx_side
    int rx_hold;
    int rr;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      rr = $urandom_range(0, 99);
      rx_hold = (rr < 70) ? $urandom_range(0, 2) : (rr < 95) ? $urandom_range(3, 14) :
                $urandom_range(30, 80);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker, sampled mid-cycle so the beat is stable for the next edge
  always @(negedge clk) begin : result_chk
    sel_result_t got;
    sel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      {got.flow_id, got.pkt_id, got.arrival, got.len, got.sel} = out_tdata;
      if (sel_exp_q.size() == 0) begin
        n_fail++;
        $error("result beat with no command outstanding, status %0h", got.status);
      end else begin
        want = sel_exp_q.pop_front();
        n_checked++;
        if (got.status !== want.status)
          report_field("status", 64'(want.status), 64'(got.status));
        if (got.sel !== want.sel)
          report_field("sel_index", 64'(want.sel), 64'(got.sel));
        if (got.len !== want.len)
          report_field("out_length", 64'(want.len), 64'(got.len));
        if (got.arrival !== want.arrival)
          report_field("out_arrival", 64'(want.arrival), 64'(got.arrival));
        if (got.pkt_id !== want.pkt_id)
          report_field("out_pkt_id", 64'(want.pkt_id), 64'(got.pkt_id));
        if (got.flow_id !== want.flow_id)
          report_field("out_flow_id", 64'(want.flow_id), 64'(got.flow_id));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("tb_aged_longest_packet_selector_unit NOT OK");
      $finish;
    end
  end

  initial begin
    pkt_cmd_t c;
    sel_result_t none;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] thr;
    logic [TIME_W-1:0] arr;
    logic [LEN_W-1:0] len;
    int ts;
    int r;
    int pp;
    int pause_at;
    int n_fill;

    none = '0;
    // reset threshold 1000: equal wait is not eligible, zero length never wins,
    // a future arrival never qualifies, ties go to the earliest entry
    add_row(typed_row(mk_pop(rand48()), status_only(ST_EMPTY)));
    add_row(typed_row(mk_push('0, '0, '0, '0), status_only(ST_PUSHED)));
    add_row(typed_row(mk_push('1, 48'd100, '1, '1), status_only(ST_PUSHED)));
    add_row(typed_row(mk_push(16'd500, TIME_MAX, 32'h1234, 32'h55),
                      status_only(ST_PUSHED)));
    add_row(typed_row(mk_push(16'd500, 48'd200, 32'hAAAA_5555, 32'h7),
                      status_only(ST_PUSHED)));
    add_row(typed_row(mk_push('1, 48'd150, 32'h8000_0001, 32'h0F0F_F0F0),
                      status_only(ST_PUSHED)));
    add_row(item_row(mk_pop(48'd1100)));
    add_row(item_row(mk_pop(48'd1101)));
    add_row(item_row(mk_pop(TIME_MAX)));
    add_row(item_row(mk_pop(TIME_MAX)));
    add_row(item_row(mk_pop(48'd0)));
    add_row(typed_row(mk_pop(TIME_MAX), status_only(ST_EMPTY)));
    // threshold zero: any positive wait qualifies, tie on length picks the earlier
    add_row(cfg_row('0));
    add_row(item_row(mk_push(16'd10, 48'd5, 32'd1, 32'd1)));
    add_row(item_row(mk_push(16'd20, 48'd5, 32'd2, 32'd1)));
    add_row(item_row(mk_push(16'd20, 48'd6, 32'd3, 32'd2)));
    add_row(item_row(mk_pop(48'd7)));
    add_row(item_row(mk_pop(48'd5)));
    add_row(item_row(mk_pop(48'd6)));
    // threshold at its top: nothing ages enough, the head always goes
    add_row(cfg_row(TIME_MAX));
    add_row(item_row(mk_push(16'd3, 48'd0, 32'd9, 32'd9)));
    add_row(item_row(mk_push('1, 48'd0, 32'd10, 32'd9)));
    add_row(item_row(mk_pop(TIME_MAX)));
    add_row(item_row(mk_pop(TIME_MAX)));
    add_row(cfg_row(THR_RESET));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    rx_idle_en <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_results();
        write_threshold(plan[i].thr);
      end else begin
        send_item(plan[i].c, plan[i].typed, plan[i].want);
      end
    end

    // random phases, one threshold each
    tick = rand48();
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      if (ph == 0) thr = '0;
      else if (ph == 1) thr = TIME_MAX;
      else if (ph == 2) thr = THR_RESET;
      else begin
        r = $urandom_range(0, 3);
        if (r == 0) thr = rand48();
        else if (r == 1) thr = TIME_W'($urandom_range(0, 20));
        else thr = TIME_W'($urandom_range(1, 5000));
      end
      write_threshold(thr);
      tx_idle_en = (ph % 4) != 3;
      rx_idle_en <= (ph % 3) != 2;
      ts = (age_thr > 20000) ? 20000 : int'(age_thr);
      pause_at = $urandom_range(5, 18);
      for (int k = 0; k < 24; k++) begin
        if (k == pause_at) drain_results();
        tick += $urandom_range(0, ts / 4 + 1);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // noise: every field random
          c.cmd = CMD_W'($urandom);
          c.len = LEN_W'($urandom);
          c.arrival = rand48();
          c.pkt_id = $urandom;
          c.flow_id = $urandom;
          c.now = rand48();
        end else begin
          pp = (pkt_q.size() < 4) ? 80 : (pkt_q.size() > 48) ? 25 : 55;
          if ($urandom_range(0, 99) < pp) begin
            r = $urandom_range(0, 99);
            if (r < 10) len = '0;
            else if (r < 25) len = ($urandom_range(0, 1) != 0) ? 16'd300 : 16'd600;
            else if (r < 30) len = '1;
            else len = LEN_W'($urandom);
            if ($urandom_range(0, 99) < 5) arr = tick + $urandom_range(1, 1000);
            else arr = tick - $urandom_range(0, ts);
            c = mk_push(len, arr, $urandom, $urandom);
          end else if (pkt_q.size() != 0 && $urandom_range(0, 9) == 0) begin
            // land exactly on or one past the age boundary of some entry
            c = mk_pop(pkt_q[$urandom_range(0, pkt_q.size() - 1)].arrival + age_thr +
                       $urandom_range(0, 1));
          end else begin
            c = mk_pop(tick + $urandom_range(0, 2 * ts + 2));
          end
        end
        send_item(c, 1'b0, none);
      end
    end

    // fill past the window: long entries behind it must stay untouched
    drain_results();
    write_threshold(TIME_W'($urandom_range(0, 500)));
    tx_idle_en = 1'b1;
    rx_idle_en <= 1'b1;
    n_fill = WIN + 16 - pkt_q.size();
    for (int k = 0; k < n_fill; k++) begin
      tick += $urandom_range(0, 3);
      if (pkt_q.size() >= WIN && $urandom_range(0, 3) == 0) len = '1;
      else len = LEN_W'($urandom_range(0, 60000));
      send_item(mk_push(len, tick - $urandom_range(0, 50), $urandom, $urandom), 1'b0, none);
    end
    for (int k = 0; k < 3; k++) send_item(mk_pop(tick + age_thr + 1000), 1'b0, none);
    for (int k = 0; k < 4; k++)
      send_item(mk_push(LEN_W'($urandom), tick, $urandom, $urandom), 1'b0, none);
    send_item(mk_pop(rand48()), 1'b0, none);

    // let any stray beat show up before judging
    drain_results();
    repeat (1400) @(posedge clk);
    $display("covered %0d commands: %0d pushed, %0d popped, %0d refused full, %0d empty pops",
             n_sent, n_by_status[ST_PUSHED], n_by_status[ST_POPPED], n_by_status[ST_FULL],
             n_by_status[ST_EMPTY]);
    $display("%0d result beats checked, %0d threshold writes, peak occupancy %0d",
             n_checked, n_thr_wr, max_occ);
    if (n_fail == 0) begin
      $display("tb_aged_longest_packet_selector_unit OK");
    end else begin
      $display("tb_aged_longest_packet_selector_unit NOT OK");
    end
    $finish;
  end

endmodule
